>>> sv/ccp_pkg.sv
package ccp_pkg;

  localparam logic [1:0] CMD_AAD  = 2'd0;
  localparam logic [1:0] CMD_TEXT = 2'd1;
  localparam logic [1:0] CMD_FIN  = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_ORDER    = 2'd2;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_FIN  = 1'b1;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_AAD  = 2'd1;
  localparam logic [1:0] PHASE_TEXT = 2'd2;

  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_NONCE_L = 3'd4;
  localparam logic [2:0] REG_NONCE_H = 3'd5;
  localparam logic [2:0] REG_DECRYPT = 3'd6;

  localparam logic [4:0] CHUNK_BYTES = 5'd16;
  localparam logic [4:0] WORD_BYTES  = 5'd8;

  localparam logic [31:0] LIMB_MASK = 32'h03ffffff;
  localparam logic [25:0] CLAMP_1   = 26'h3ffff03;
  localparam logic [25:0] CLAMP_2   = 26'h3ffc0ff;
  localparam logic [25:0] CLAMP_3   = 26'h3f03fff;
  localparam logic [25:0] CLAMP_4   = 26'h00fffff;
  localparam logic [31:0] HIBIT     = 32'h01000000;
  localparam logic [31:0] LIMB_TOP  = 32'h04000000;

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  localparam logic [4:0] LAST_ROUND = 5'd19;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  n;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  bytes;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic load;
    logic absorb;
    logic tag;
  } poly_ctl_t;

  function automatic logic [63:0] byte_mask(input logic [4:0] k);
    logic [63:0] m;
    for (int b = 0; b < 8; b++) begin
      m[8*b +: 8] = (k > 5'(b)) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [4:0] hi_count(input logic [4:0] k);
    return (k > WORD_BYTES) ? 5'(k - WORD_BYTES) : 5'd0;
  endfunction

  function automatic logic [127:0] qround(input logic [31:0] a_i, input logic [31:0] b_i,
                                          input logic [31:0] c_i, input logic [31:0] d_i);
    logic [31:0] a, b, c, d;
    a = a_i; b = b_i; c = c_i; d = d_i;
    a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
    c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
    a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
    c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
    return {a, b, c, d};
  endfunction

endpackage

>>> sv/chacha20_poly1305_aead_core.sv
// ChaCha20-Poly1305 AEAD engine, one 16-byte chunk per input transfer.
// Load key, nonce and mode through the write port while the engine is idle.
// Input channel (in_valid/in_ready): cmd 0 carries associated data, cmd 1
// payload, cmd 2 closes the message (on decrypt, data holds the expected tag).
// The first item of a message first runs ChaCha20 block 0 to derive the
// Poly1305 key.
// Output channel (out_valid/out_ready): one transfer per payload chunk with the
// XORed bytes, and one per finish with the tag or the verify status.
// Decrypted payload leaves before the verdict; drop it on a mismatch.
// Work per absorbed chunk is set by the single shared Poly1305 multiplier (25
// products, then a carry pass and a fold); a payload chunk that opens a new
// keystream block first runs the 20-round core, one round per cycle, and
// finish adds the tag steps. Items are worked one at a time: the next item
// is taken from the queue only after the last one is done.
// A two-entry input queue and a one-deep output register decouple the sides:
// input stays open while a result waits; a stalled receiver stops the engine
// once the output register is full and the next result is ready, and input
// then closes when the queue fills.
// Reset (synchronous, active high) clears the configuration and control registers and ends any message.
module chacha20_poly1305_aead_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   cmd,
  input  logic [63:0]  data_low,
  input  logic [63:0]  data_high,
  input  logic [4:0]   valid_bytes,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         kind,
  output logic [63:0]  out_low,
  output logic [63:0]  out_high,
  output logic [4:0]   out_bytes,
  output logic [1:0]   status
);

  logic [63:0] key_0, key_1, key_2, key_3, nonce_low;
  logic [31:0] nonce_high;
  logic decrypt_mode;

  ccp_pkg::item_t q_item;
  logic q_valid, q_pop;
  ccp_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_0 <= 64'd0;
      key_1 <= 64'd0;
      key_2 <= 64'd0;
      key_3 <= 64'd0;
      nonce_low <= 64'd0;
      nonce_high <= 32'd0;
      decrypt_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ccp_pkg::REG_KEY0:    key_0 <= cfg_data;
        ccp_pkg::REG_KEY1:    key_1 <= cfg_data;
        ccp_pkg::REG_KEY2:    key_2 <= cfg_data;
        ccp_pkg::REG_KEY3:    key_3 <= cfg_data;
        ccp_pkg::REG_NONCE_L: nonce_low <= cfg_data;
        ccp_pkg::REG_NONCE_H: nonce_high <= cfg_data[31:0];
        ccp_pkg::REG_DECRYPT: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ccp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .data_low    (data_low),
    .data_high   (data_high),
    .valid_bytes (valid_bytes),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_pop       (q_pop)
  );

  ccp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .key       ({key_3, key_2, key_1, key_0}),
    .nonce     ({nonce_high, nonce_low}),
    .decrypt   (decrypt_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign kind = res.kind;
  assign out_low = res.lo;
  assign out_high = res.hi;
  assign out_bytes = res.bytes;
  assign status = res.status;

endmodule

>>> sv/ccp_front.sv
module ccp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic [63:0]         data_low,
  input  logic [63:0]         data_high,
  input  logic [4:0]          valid_bytes,
  output ccp_pkg::item_t      q_item,
  output logic                q_valid,
  input  logic                q_pop
);

  ccp_pkg::item_t mem [2];
  logic [1:0] count;
  logic wr_ptr, rd_ptr;
  logic take, push, pop;
  logic [4:0] nc;
  ccp_pkg::item_t item_in;

  assign in_ready = (count != 2'd2);
  assign take = in_valid && in_ready;
  // unknown commands are taken and dropped
  assign push = take && (cmd != ccp_pkg::CMD_NONE);
  assign pop = q_pop && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_item = mem[rd_ptr];

  always_comb begin
    nc = (valid_bytes > ccp_pkg::CHUNK_BYTES) ? ccp_pkg::CHUNK_BYTES : valid_bytes;
    item_in.cmd = cmd;
    item_in.n = nc;
    // finish carries the expected tag unmasked
    if (cmd == ccp_pkg::CMD_FIN) begin
      item_in.lo = data_low;
      item_in.hi = data_high;
    end else begin
      item_in.lo = data_low & ccp_pkg::byte_mask(nc);
      item_in.hi = data_high & ccp_pkg::byte_mask(ccp_pkg::hi_count(nc));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/ccp_chacha.sv
module ccp_chacha (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [255:0]  key,
  input  logic [95:0]   nonce,
  input  logic [31:0]   ctr,
  output logic [31:0]   blk [16],
  output logic          done
);

  typedef enum logic [2:0] {
    CC_IDLE = 3'b001,
    CC_RUN  = 3'b010,
    CC_FIN  = 3'b100
  } cc_state_t;

  cc_state_t st;
  logic [31:0] x [16];
  logic [31:0] init [16];
  logic [31:0] nx [16];
  logic [4:0] rnd;

  assign blk = x;

  always_comb begin
    init[0] = ccp_pkg::SIGMA_0;
    init[1] = ccp_pkg::SIGMA_1;
    init[2] = ccp_pkg::SIGMA_2;
    init[3] = ccp_pkg::SIGMA_3;
    for (int i = 0; i < 8; i++) begin
      init[4 + i] = key[32*i +: 32];
    end
    init[12] = ctr;
    init[13] = nonce[31:0];
    init[14] = nonce[63:32];
    init[15] = nonce[95:64];
  end

  // even rounds mix columns, odd rounds mix diagonals
  always_comb begin
    logic [127:0] q0, q1, q2, q3;
    if (!rnd[0]) begin
      q0 = ccp_pkg::qround(x[0], x[4], x[8],  x[12]);
      q1 = ccp_pkg::qround(x[1], x[5], x[9],  x[13]);
      q2 = ccp_pkg::qround(x[2], x[6], x[10], x[14]);
      q3 = ccp_pkg::qround(x[3], x[7], x[11], x[15]);
      {nx[0], nx[4], nx[8],  nx[12]} = q0;
      {nx[1], nx[5], nx[9],  nx[13]} = q1;
      {nx[2], nx[6], nx[10], nx[14]} = q2;
      {nx[3], nx[7], nx[11], nx[15]} = q3;
    end else begin
      q0 = ccp_pkg::qround(x[0], x[5], x[10], x[15]);
      q1 = ccp_pkg::qround(x[1], x[6], x[11], x[12]);
      q2 = ccp_pkg::qround(x[2], x[7], x[8],  x[13]);
      q3 = ccp_pkg::qround(x[3], x[4], x[9],  x[14]);
      {nx[0], nx[5], nx[10], nx[15]} = q0;
      {nx[1], nx[6], nx[11], nx[12]} = q1;
      {nx[2], nx[7], nx[8],  nx[13]} = q2;
      {nx[3], nx[4], nx[9],  nx[14]} = q3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= CC_IDLE;
      done <= 1'b0;
      rnd <= 5'd0;
    end else begin
      done <= (st == CC_FIN);
      case (st)
        CC_IDLE: begin
          if (start) begin
            x <= init;
            rnd <= 5'd0;
            st <= CC_RUN;
          end
        end
        CC_RUN: begin
          x <= nx;
          rnd <= rnd + 5'd1;
          if (rnd == ccp_pkg::LAST_ROUND) st <= CC_FIN;
        end
        CC_FIN: begin
          for (int i = 0; i < 16; i++) begin
            x[i] <= x[i] + init[i];
          end
          st <= CC_IDLE;
        end
        default: st <= CC_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ccp_poly.sv
module ccp_poly (
  input  logic                 clk,
  input  logic                 rst,
  input  ccp_pkg::poly_ctl_t   ctl,
  input  logic [255:0]         blk0,
  input  logic [127:0]         w,
  output logic                 done,
  output logic [127:0]         tag
);

  typedef enum logic [6:0] {
    P_IDLE  = 7'b0000001,
    P_MUL   = 7'b0000010,
    P_CARRY = 7'b0000100,
    P_FOLD  = 7'b0001000,
    P_T1    = 7'b0010000,
    P_T2    = 7'b0100000,
    P_T3    = 7'b1000000
  } p_state_t;

  p_state_t st;
  logic [25:0] r [5];
  logic [28:0] sr [4];
  logic [31:0] sw [4];
  logic [26:0] acc [5];
  logic [31:0] h [5];
  logic [63:0] d [5];
  logic [2:0] i, j, cs, cs1;
  logic [31:0] cr;

  logic [25:0] rl [5];
  logic [31:0] hin [5];
  logic [2:0] k;
  logic [31:0] coef;
  logic [63:0] prod;
  logic [31:0] f0;
  logic [31:0] t1v [5];
  logic [31:0] t2v [5];
  logic [127:0] sum;

  // clamp r from the low half of blk0, the first 16 bytes of block zero
  always_comb begin
    logic [31:0] b0, b1, b2, b3, u1, u2, u3;
    b0 = blk0[31:0];
    b1 = blk0[63:32];
    b2 = blk0[95:64];
    b3 = blk0[127:96];
    u1 = (b0 >> 26) | (b1 << 6);
    u2 = (b1 >> 20) | (b2 << 12);
    u3 = (b2 >> 14) | (b3 << 18);
    rl[0] = b0[25:0];
    rl[1] = u1[25:0] & ccp_pkg::CLAMP_1;
    rl[2] = u2[25:0] & ccp_pkg::CLAMP_2;
    rl[3] = u3[25:0] & ccp_pkg::CLAMP_3;
    rl[4] = 26'(b3[31:8]) & ccp_pkg::CLAMP_4;
  end

  always_comb begin
    logic [31:0] w0, w1, w2, w3, u1, u2, u3;
    w0 = w[31:0];
    w1 = w[63:32];
    w2 = w[95:64];
    w3 = w[127:96];
    u1 = ((w0 >> 26) | (w1 << 6)) & ccp_pkg::LIMB_MASK;
    u2 = ((w1 >> 20) | (w2 << 12)) & ccp_pkg::LIMB_MASK;
    u3 = ((w2 >> 14) | (w3 << 18)) & ccp_pkg::LIMB_MASK;
    hin[0] = 32'(acc[0]) + (w0 & ccp_pkg::LIMB_MASK);
    hin[1] = 32'(acc[1]) + u1;
    hin[2] = 32'(acc[2]) + u2;
    hin[3] = 32'(acc[3]) + u3;
    hin[4] = 32'(acc[4]) + ((w3 >> 8) | ccp_pkg::HIBIT);
  end

  // product h[i] * r[j-i], wrapping to 5*r past the top limb
  always_comb begin
    if (i <= j) begin
      k = j - i;
      coef = 32'(r[k]);
    end else begin
      k = j + 3'd5 - i;
      coef = 32'(sr[2'(k - 3'd1)]);
    end
  end

  assign prod = 64'(h[i]) * 64'(coef);
  assign cs1 = cs + 3'd1;
  assign f0 = 32'(acc[0]) + cr * 32'd5;

  always_comb begin
    logic [31:0] a0, a1, a2, a3, a4, c;
    a0 = 32'(acc[0]); a1 = 32'(acc[1]); a2 = 32'(acc[2]);
    a3 = 32'(acc[3]); a4 = 32'(acc[4]);
    c = a1 >> 26; a1 = a1 & ccp_pkg::LIMB_MASK;
    a2 = a2 + c; c = a2 >> 26; a2 = a2 & ccp_pkg::LIMB_MASK;
    a3 = a3 + c; c = a3 >> 26; a3 = a3 & ccp_pkg::LIMB_MASK;
    a4 = a4 + c; c = a4 >> 26; a4 = a4 & ccp_pkg::LIMB_MASK;
    a0 = a0 + c * 32'd5; c = a0 >> 26; a0 = a0 & ccp_pkg::LIMB_MASK;
    a1 = a1 + c;
    t1v[0] = a0; t1v[1] = a1; t1v[2] = a2; t1v[3] = a3; t1v[4] = a4;
  end

  // final reduction: take h - p when it does not go negative
  always_comb begin
    logic [31:0] g0, g1, g2, g3, g4, c, m;
    g0 = h[0] + 32'd5; c = g0 >> 26; g0 = g0 & ccp_pkg::LIMB_MASK;
    g1 = h[1] + c; c = g1 >> 26; g1 = g1 & ccp_pkg::LIMB_MASK;
    g2 = h[2] + c; c = g2 >> 26; g2 = g2 & ccp_pkg::LIMB_MASK;
    g3 = h[3] + c; c = g3 >> 26; g3 = g3 & ccp_pkg::LIMB_MASK;
    g4 = h[4] + c - ccp_pkg::LIMB_TOP;
    m = g4[31] ? 32'd0 : 32'hffffffff;
    t2v[0] = (h[0] & ~m) | (g0 & m);
    t2v[1] = (h[1] & ~m) | (g1 & m);
    t2v[2] = (h[2] & ~m) | (g2 & m);
    t2v[3] = (h[3] & ~m) | (g3 & m);
    t2v[4] = (h[4] & ~m) | (g4 & m);
  end

  always_comb begin
    logic [31:0] t0, t1, t2, t3;
    t0 = h[0] | (h[1] << 26);
    t1 = (h[1] >> 6) | (h[2] << 20);
    t2 = (h[2] >> 12) | (h[3] << 14);
    t3 = (h[3] >> 18) | (h[4] << 8);
    sum = {t3, t2, t1, t0} + {sw[3], sw[2], sw[1], sw[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= P_IDLE;
      done <= 1'b0;
      i <= 3'd0;
      j <= 3'd0;
      cs <= 3'd0;
      for (int n = 0; n < 5; n++) acc[n] <= 27'd0;
    end else begin
      done <= (st == P_FOLD) || (st == P_T3);
      case (st)
        P_IDLE: begin
          if (ctl.load) begin
            r <= rl;
            for (int n = 0; n < 4; n++) begin
              sr[n] <= 29'(rl[n + 1]) * 29'd5;
              sw[n] <= blk0[128 + 32*n +: 32];
            end
            for (int n = 0; n < 5; n++) acc[n] <= 27'd0;
          end else if (ctl.absorb) begin
            h <= hin;
            for (int n = 0; n < 5; n++) d[n] <= 64'd0;
            i <= 3'd0;
            j <= 3'd0;
            st <= P_MUL;
          end else if (ctl.tag) begin
            st <= P_T1;
          end
        end
        P_MUL: begin
          d[j] <= d[j] + prod;
          if (j == 3'd4) begin
            j <= 3'd0;
            if (i == 3'd4) begin
              cs <= 3'd0;
              st <= P_CARRY;
            end else begin
              i <= i + 3'd1;
            end
          end else begin
            j <= j + 3'd1;
          end
        end
        P_CARRY: begin
          acc[cs] <= {1'b0, d[cs][25:0]};
          if (cs == 3'd4) begin
            cr <= d[cs][57:26];
            st <= P_FOLD;
          end else begin
            d[cs1] <= d[cs1] + 64'(d[cs][57:26]);
            cs <= cs1;
          end
        end
        P_FOLD: begin
          acc[0] <= {1'b0, f0[25:0]};
          acc[1] <= acc[1] + 27'(f0[31:26]);
          st <= P_IDLE;
        end
        P_T1: begin
          h <= t1v;
          st <= P_T2;
        end
        P_T2: begin
          h <= t2v;
          st <= P_T3;
        end
        P_T3: begin
          tag <= sum;
          st <= P_IDLE;
        end
        default: st <= P_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ccp_back.sv
module ccp_back (
  input  logic                clk,
  input  logic                rst,
  input  ccp_pkg::item_t      q_item,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic [255:0]        key,
  input  logic [95:0]         nonce,
  input  logic                decrypt,
  output logic                out_valid,
  input  logic                out_ready,
  output ccp_pkg::res_t       out_res
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_KS0  = 8'b00000010,
    S_EXEC = 8'b00000100,
    S_KS   = 8'b00001000,
    S_XOR  = 8'b00010000,
    S_MAC  = 8'b00100000,
    S_TAG  = 8'b01000000,
    S_EMIT = 8'b10000000
  } b_state_t;

  b_state_t st;
  ccp_pkg::item_t cur;
  ccp_pkg::res_t res;
  logic [1:0] phase;
  logic oerr;
  logic [31:0] ctr;
  logic [1:0] cib;
  logic [63:0] aad_len, text_len;

  logic cc_start, cc_done;
  logic [31:0] cc_ctr;
  logic [31:0] ks [16];
  ccp_pkg::poly_ctl_t pctl;
  logic p_done;
  logic [127:0] p_w, p_tag;
  logic [255:0] blk0;
  logic [63:0] ks_lo, ks_hi, r_lo, r_hi;
  logic aad_mac;

  assign q_pop = (st == S_IDLE) && q_valid;

  assign cc_start = ((st == S_IDLE) && q_valid && (phase == ccp_pkg::PHASE_IDLE)) ||
                    ((st == S_EXEC) && (cur.cmd == ccp_pkg::CMD_TEXT) &&
                     (cur.n != 5'd0) && (cib == 2'd0));
  assign cc_ctr = (st == S_IDLE) ? 32'd0 : ctr;

  ccp_chacha u_chacha (
    .clk   (clk),
    .rst   (rst),
    .start (cc_start),
    .key   (key),
    .nonce (nonce),
    .ctr   (cc_ctr),
    .blk   (ks),
    .done  (cc_done)
  );

  always_comb begin
    for (int n = 0; n < 8; n++) blk0[32*n +: 32] = ks[n];
  end

  always_comb begin
    ks_lo = {ks[{cib, 2'd1}], ks[{cib, 2'd0}]};
    ks_hi = {ks[{cib, 2'd3}], ks[{cib, 2'd2}]};
    r_lo = (cur.lo ^ ks_lo) & ccp_pkg::byte_mask(cur.n);
    r_hi = (cur.hi ^ ks_hi) & ccp_pkg::byte_mask(ccp_pkg::hi_count(cur.n));
  end

  assign aad_mac = (cur.cmd == ccp_pkg::CMD_AAD) && (phase != ccp_pkg::PHASE_TEXT) &&
                   (cur.n != 5'd0);

  always_comb begin
    pctl.load = (st == S_KS0) && cc_done;
    pctl.absorb = ((st == S_EXEC) && (aad_mac || (cur.cmd == ccp_pkg::CMD_FIN))) ||
                  (st == S_XOR);
    pctl.tag = (st == S_MAC) && p_done && (cur.cmd == ccp_pkg::CMD_FIN);
    if (st == S_XOR) begin
      p_w = decrypt ? {cur.hi, cur.lo} : {r_hi, r_lo};
    end else if (cur.cmd == ccp_pkg::CMD_FIN) begin
      p_w = {text_len, aad_len};
    end else begin
      p_w = {cur.hi, cur.lo};
    end
  end

  ccp_poly u_poly (
    .clk  (clk),
    .rst  (rst),
    .ctl  (pctl),
    .blk0 (blk0),
    .w    (p_w),
    .done (p_done),
    .tag  (p_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      phase <= ccp_pkg::PHASE_IDLE;
      oerr <= 1'b0;
      ctr <= 32'd1;
      cib <= 2'd0;
      aad_len <= 64'd0;
      text_len <= 64'd0;
      out_valid <= 1'b0;
    end else begin
      // load the output register when it is free or being drained
      if ((st == S_EMIT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            st <= (phase == ccp_pkg::PHASE_IDLE) ? S_KS0 : S_EXEC;
          end
        end
        S_KS0: begin
          if (cc_done) begin
            ctr <= 32'd1;
            cib <= 2'd0;
            oerr <= 1'b0;
            aad_len <= 64'd0;
            text_len <= 64'd0;
            st <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cur.cmd)
            ccp_pkg::CMD_AAD: begin
              if (phase == ccp_pkg::PHASE_TEXT) begin
                oerr <= 1'b1;
                st <= S_IDLE;
              end else begin
                phase <= ccp_pkg::PHASE_AAD;
                if (aad_mac) begin
                  aad_len <= aad_len + 64'(cur.n);
                  st <= S_MAC;
                end else begin
                  st <= S_IDLE;
                end
              end
            end
            ccp_pkg::CMD_TEXT: begin
              phase <= ccp_pkg::PHASE_TEXT;
              if (cur.n == 5'd0) begin
                res <= '{kind: ccp_pkg::KIND_TEXT, lo: 64'd0, hi: 64'd0, bytes: 5'd0,
                         status: ccp_pkg::STAT_OK};
                st <= S_EMIT;
              end else if (cib == 2'd0) begin
                st <= S_KS;
              end else begin
                st <= S_XOR;
              end
            end
            default: st <= S_MAC;
          endcase
        end
        S_KS: begin
          if (cc_done) st <= S_XOR;
        end
        S_XOR: begin
          res <= '{kind: ccp_pkg::KIND_TEXT, lo: r_lo, hi: r_hi, bytes: cur.n,
                   status: ccp_pkg::STAT_OK};
          text_len <= text_len + 64'(cur.n);
          cib <= cib + 2'd1;
          if (cib == 2'd3) ctr <= ctr + 32'd1;
          st <= S_MAC;
        end
        S_MAC: begin
          if (p_done) begin
            case (cur.cmd)
              ccp_pkg::CMD_FIN:  st <= S_TAG;
              ccp_pkg::CMD_TEXT: st <= S_EMIT;
              default:           st <= S_IDLE;
            endcase
          end
        end
        S_TAG: begin
          if (p_done) begin
            if (oerr) begin
              res <= '{kind: ccp_pkg::KIND_FIN, lo: 64'd0, hi: 64'd0, bytes: 5'd0,
                       status: ccp_pkg::STAT_ORDER};
            end else if (decrypt) begin
              res <= '{kind: ccp_pkg::KIND_FIN, lo: 64'd0, hi: 64'd0, bytes: 5'd0,
                       status: (p_tag != {cur.hi, cur.lo}) ? ccp_pkg::STAT_MISMATCH
                                                          : ccp_pkg::STAT_OK};
            end else begin
              res <= '{kind: ccp_pkg::KIND_FIN, lo: p_tag[63:0], hi: p_tag[127:64],
                       bytes: ccp_pkg::CHUNK_BYTES, status: ccp_pkg::STAT_OK};
            end
            phase <= ccp_pkg::PHASE_IDLE;
            oerr <= 1'b0;
            st <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the output register is free or being drained
          if (!out_valid || out_ready) begin
            out_res <= res;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sim/testbench.sv
module testbench;

  class aead_scoreboard;
    bit [63:0] key [4];
    bit [63:0] nonce_l;
    bit [31:0] nonce_h;
    bit        dec;

    bit [15:0][31:0] ks;
    bit [31:0]       blk_ctr = 1;
    bit [1:0]        chunk_pos;
    bit [4:0][31:0]  r;
    bit [3:0][31:0]  s;
    bit [4:0][31:0]  acc;
    bit [63:0]       aad_len;
    bit [63:0]       text_len;
    bit [1:0]        phase;
    bit              order_err;

    ccp_pkg::res_t expq[$];
    int   errors;

    function void write_reg(bit [2:0] idx, bit [63:0] v);
      case (idx)
        ccp_pkg::REG_KEY0:    key[0] = v;
        ccp_pkg::REG_KEY1:    key[1] = v;
        ccp_pkg::REG_KEY2:    key[2] = v;
        ccp_pkg::REG_KEY3:    key[3] = v;
        ccp_pkg::REG_NONCE_L: nonce_l = v;
        ccp_pkg::REG_NONCE_H: nonce_h = v[31:0];
        ccp_pkg::REG_DECRYPT: dec = v[0];
        default: ;
      endcase
    endfunction

    function bit [31:0] rotl(bit [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function bit [15:0][31:0] mix(bit [15:0][31:0] x, int a, int b, int c, int d);
      x[a] += x[b]; x[d] = rotl(x[d] ^ x[a], 16);
      x[c] += x[d]; x[b] = rotl(x[b] ^ x[c], 12);
      x[a] += x[b]; x[d] = rotl(x[d] ^ x[a], 8);
      x[c] += x[d]; x[b] = rotl(x[b] ^ x[c], 7);
      return x;
    endfunction

    function bit [15:0][31:0] keystream(bit [31:0] ctr);
      bit [15:0][31:0] init, x;
      init[0] = ccp_pkg::SIGMA_0; init[1] = ccp_pkg::SIGMA_1;
      init[2] = ccp_pkg::SIGMA_2; init[3] = ccp_pkg::SIGMA_3;
      for (int i = 0; i < 4; i++) begin
        init[4 + 2*i] = key[i][31:0];
        init[5 + 2*i] = key[i][63:32];
      end
      init[12] = ctr;
      init[13] = nonce_l[31:0];
      init[14] = nonce_l[63:32];
      init[15] = nonce_h;
      x = init;
      for (int i = 0; i < 10; i++) begin
        x = mix(x, 0, 4, 8, 12);  x = mix(x, 1, 5, 9, 13);
        x = mix(x, 2, 6, 10, 14); x = mix(x, 3, 7, 11, 15);
        x = mix(x, 0, 5, 10, 15); x = mix(x, 1, 6, 11, 12);
        x = mix(x, 2, 7, 8, 13);  x = mix(x, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) x[i] = x[i] + init[i];
      return x;
    endfunction

    function bit [4:0][31:0] absorb(bit [4:0][31:0] a, bit [3:0][31:0] w);
      bit [31:0] h0, h1, h2, h3, h4, s1, s2, s3, s4, c;
      bit [63:0] d0, d1, d2, d3, d4;
      s1 = r[1] * 5; s2 = r[2] * 5; s3 = r[3] * 5; s4 = r[4] * 5;
      h0 = a[0] + (w[0] & ccp_pkg::LIMB_MASK);
      h1 = a[1] + (((w[0] >> 26) | (w[1] << 6)) & ccp_pkg::LIMB_MASK);
      h2 = a[2] + (((w[1] >> 20) | (w[2] << 12)) & ccp_pkg::LIMB_MASK);
      h3 = a[3] + (((w[2] >> 14) | (w[3] << 18)) & ccp_pkg::LIMB_MASK);
      h4 = a[4] + ((w[3] >> 8) | ccp_pkg::HIBIT);
      d0 = 64'(h0)*r[0] + 64'(h1)*s4 + 64'(h2)*s3 + 64'(h3)*s2 + 64'(h4)*s1;
      d1 = 64'(h0)*r[1] + 64'(h1)*r[0] + 64'(h2)*s4 + 64'(h3)*s3 + 64'(h4)*s2;
      d2 = 64'(h0)*r[2] + 64'(h1)*r[1] + 64'(h2)*r[0] + 64'(h3)*s4 + 64'(h4)*s3;
      d3 = 64'(h0)*r[3] + 64'(h1)*r[2] + 64'(h2)*r[1] + 64'(h3)*r[0] + 64'(h4)*s4;
      d4 = 64'(h0)*r[4] + 64'(h1)*r[3] + 64'(h2)*r[2] + 64'(h3)*r[1] + 64'(h4)*r[0];
      c = 32'(d0 >> 26); h0 = d0[31:0] & ccp_pkg::LIMB_MASK;
      d1 += c; c = 32'(d1 >> 26); h1 = d1[31:0] & ccp_pkg::LIMB_MASK;
      d2 += c; c = 32'(d2 >> 26); h2 = d2[31:0] & ccp_pkg::LIMB_MASK;
      d3 += c; c = 32'(d3 >> 26); h3 = d3[31:0] & ccp_pkg::LIMB_MASK;
      d4 += c; c = 32'(d4 >> 26); h4 = d4[31:0] & ccp_pkg::LIMB_MASK;
      h0 += c * 5; c = h0 >> 26; h0 &= ccp_pkg::LIMB_MASK; h1 += c;
      return {h4, h3, h2, h1, h0};
    endfunction

    function bit [127:0] tag_of(bit [4:0][31:0] a);
      bit [31:0] h0, h1, h2, h3, h4, g0, g1, g2, g3, g4, c, m;
      bit [3:0][31:0] t;
      bit [63:0] f;
      h0 = a[0]; h1 = a[1]; h2 = a[2]; h3 = a[3]; h4 = a[4];
      c = h1 >> 26; h1 &= ccp_pkg::LIMB_MASK;
      h2 += c; c = h2 >> 26; h2 &= ccp_pkg::LIMB_MASK;
      h3 += c; c = h3 >> 26; h3 &= ccp_pkg::LIMB_MASK;
      h4 += c; c = h4 >> 26; h4 &= ccp_pkg::LIMB_MASK;
      h0 += c * 5; c = h0 >> 26; h0 &= ccp_pkg::LIMB_MASK; h1 += c;
      g0 = h0 + 5; c = g0 >> 26; g0 &= ccp_pkg::LIMB_MASK;
      g1 = h1 + c; c = g1 >> 26; g1 &= ccp_pkg::LIMB_MASK;
      g2 = h2 + c; c = g2 >> 26; g2 &= ccp_pkg::LIMB_MASK;
      g3 = h3 + c; c = g3 >> 26; g3 &= ccp_pkg::LIMB_MASK;
      g4 = h4 + c - ccp_pkg::LIMB_TOP;
      // select h - p when it did not go negative
      m = (g4 >> 31) - 1;
      h0 = (h0 & ~m) | (g0 & m); h1 = (h1 & ~m) | (g1 & m); h2 = (h2 & ~m) | (g2 & m);
      h3 = (h3 & ~m) | (g3 & m); h4 = (h4 & ~m) | (g4 & m);
      t[0] = h0 | (h1 << 26);
      t[1] = (h1 >> 6) | (h2 << 20);
      t[2] = (h2 >> 12) | (h3 << 14);
      t[3] = (h3 >> 18) | (h4 << 8);
      f = 64'(t[0]) + s[0];             t[0] = f[31:0];
      f = 64'(t[1]) + s[1] + (f >> 32); t[1] = f[31:0];
      f = 64'(t[2]) + s[2] + (f >> 32); t[2] = f[31:0];
      f = 64'(t[3]) + s[3] + (f >> 32); t[3] = f[31:0];
      return t;
    endfunction

    function void start_msg();
      bit [15:0][31:0] b;
      b = keystream(32'd0);
      r[0] = b[0] & ccp_pkg::LIMB_MASK;
      r[1] = ((b[0] >> 26) | (b[1] << 6)) & 32'(ccp_pkg::CLAMP_1);
      r[2] = ((b[1] >> 20) | (b[2] << 12)) & 32'(ccp_pkg::CLAMP_2);
      r[3] = ((b[2] >> 14) | (b[3] << 18)) & 32'(ccp_pkg::CLAMP_3);
      r[4] = (b[3] >> 8) & 32'(ccp_pkg::CLAMP_4);
      for (int i = 0; i < 4; i++) s[i] = b[4 + i];
      acc = '0; aad_len = 0; text_len = 0;
      blk_ctr = 1; chunk_pos = 0; order_err = 0;
    endfunction

    function bit [63:0] bmask(int k);
      if (k >= 8) return '1;
      return (64'd1 << (8 * k)) - 1;
    endfunction

    // tag the engine will compute if the message is closed now
    function bit [127:0] peek_tag();
      if (phase == ccp_pkg::PHASE_IDLE) start_msg();
      return tag_of(absorb(acc, {text_len, aad_len}));
    endfunction

    function void note_input(bit [1:0] c, bit [63:0] dl, bit [63:0] dh, bit [4:0] vb);
      int n, base;
      bit [63:0] lo, hi, rl, rh;
      bit [127:0] t;
      ccp_pkg::res_t e;
      if (c == ccp_pkg::CMD_NONE) return;
      n = (vb > 16) ? 16 : vb;
      if (phase == ccp_pkg::PHASE_IDLE) start_msg();
      lo = dl & bmask(n);
      hi = dh & bmask(n > 8 ? n - 8 : 0);
      if (c == ccp_pkg::CMD_AAD) begin
        if (phase == ccp_pkg::PHASE_TEXT) begin
          order_err = 1;
          return;
        end
        phase = ccp_pkg::PHASE_AAD;
        if (n != 0) begin
          acc = absorb(acc, {hi, lo});
          aad_len += n;
        end
        return;
      end
      if (c == ccp_pkg::CMD_TEXT) begin
        phase = ccp_pkg::PHASE_TEXT;
        rl = 0; rh = 0;
        if (n != 0) begin
          base = chunk_pos * 4;
          if (chunk_pos == 0) ks = keystream(blk_ctr);
          rl = (lo ^ {ks[base + 1], ks[base]}) & bmask(n);
          rh = (hi ^ {ks[base + 3], ks[base + 2]}) & bmask(n > 8 ? n - 8 : 0);
          acc = absorb(acc, dec ? {hi, lo} : {rh, rl});
          text_len += n;
          chunk_pos++;
          if (chunk_pos == 0) blk_ctr++;
        end
        e.kind = ccp_pkg::KIND_TEXT; e.lo = rl; e.hi = rh; e.bytes = 5'(n);
        e.status = ccp_pkg::STAT_OK;
        expq.push_back(e);
        return;
      end
      t = tag_of(absorb(acc, {text_len, aad_len}));
      e.kind = ccp_pkg::KIND_FIN; e.lo = 0; e.hi = 0; e.bytes = 0;
      if (order_err) e.status = ccp_pkg::STAT_ORDER;
      else if (dec) e.status = ({dh, dl} != t) ? ccp_pkg::STAT_MISMATCH : ccp_pkg::STAT_OK;
      else begin
        e.lo = t[63:0]; e.hi = t[127:64]; e.bytes = ccp_pkg::CHUNK_BYTES;
        e.status = ccp_pkg::STAT_OK;
      end
      expq.push_back(e);
      phase = ccp_pkg::PHASE_IDLE;
      order_err = 0;
    endfunction

    function void check(ccp_pkg::res_t got);
      ccp_pkg::res_t e;
      if (expq.size() == 0) begin
        $display("%0t: unexpected result kind=%0d lo=%h hi=%h bytes=%0d status=%0d",
                 $time, got.kind, got.lo, got.hi, got.bytes, got.status);
        errors++;
        return;
      end
      e = expq.pop_front();
      if (got.kind !== e.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, got.kind); errors++;
      end
      if (got.lo !== e.lo) begin
        $display("%0t: out_low expected %h actual %h", $time, e.lo, got.lo); errors++;
      end
      if (got.hi !== e.hi) begin
        $display("%0t: out_high expected %h actual %h", $time, e.hi, got.hi); errors++;
      end
      if (got.bytes !== e.bytes) begin
        $display("%0t: out_bytes expected %0d actual %0d", $time, e.bytes, got.bytes); errors++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status); errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid, in_ready;
  logic [1:0]  cmd;
  logic [63:0] data_low, data_high;
  logic [4:0]  valid_bytes;
  logic        out_valid, out_ready;
  logic        kind;
  logic [63:0] out_low, out_high;
  logic [4:0]  out_bytes;
  logic [1:0]  status;

  chacha20_poly1305_aead_core dut (.*);

  aead_scoreboard sb = new();
  bit  quiet;
  bit  hold_req;
  int  n_sent;
  int  stall_cnt;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic bit [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [4:0] pick_len();
    if ($urandom_range(0, 9) < 7) return ccp_pkg::CHUNK_BYTES;
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic send(bit [1:0] c, bit [63:0] dl, bit [63:0] dh, bit [4:0] vb);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1; cmd = c; data_low = dl; data_high = dh; valid_bytes = vb;
    do @(posedge clk); while (!in_ready);
    sb.note_input(c, dl, dh, vb);
    if (c != ccp_pkg::CMD_NONE) n_sent++;
    @(negedge clk);
  endtask

  // let the last result land and any AAD work settle before touching registers
  task automatic drain();
    in_valid = 0;
    while (sb.expq.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic cfg_write(bit [2:0] idx, bit [63:0] v);
    cfg_we = 1; cfg_index = idx; cfg_data = v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic load_setting(int style, bit mode);
    bit [63:0] v;
    for (int i = 0; i <= 5; i++) begin
      v = (style == 0) ? 64'd0 : (style == 1) ? '1 : rnd64();
      cfg_write(3'(i), v);
    end
    cfg_write(ccp_pkg::REG_DECRYPT, {63'($urandom), mode});
  endtask

  task automatic finish_msg(bit err);
    bit [127:0] t;
    if (sb.dec && !err) begin
      t = sb.peek_tag();
      case ($urandom_range(0, 3))
        0, 1: ;
        2: t[$urandom_range(0, 127)] ^= 1'b1;
        default: t = {rnd64(), rnd64()};
      endcase
      send(ccp_pkg::CMD_FIN, t[63:0], t[127:64], pick_len());
    end else begin
      send(ccp_pkg::CMD_FIN, rnd64(), rnd64(), pick_len());
    end
  endtask

  task automatic message(int n_aad, int n_text, bit bad_order);
    for (int i = 0; i < n_aad; i++) send(ccp_pkg::CMD_AAD, rnd64(), rnd64(), pick_len());
    for (int i = 0; i < n_text; i++) begin
      if ($urandom_range(0, 19) == 0) send(ccp_pkg::CMD_NONE, rnd64(), rnd64(), pick_len());
      send(ccp_pkg::CMD_TEXT, rnd64(), rnd64(), pick_len());
    end
    if (bad_order) send(ccp_pkg::CMD_AAD, rnd64(), rnd64(), pick_len());
    finish_msg(bad_order);
  endtask

  // receiver: random short stalls, plus one long hold-off on request
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready = 0;
        repeat (400) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_ready = 1;
      end
    end
  end

  always @(posedge clk) begin : result_mon
    ccp_pkg::res_t got;
    if (!rst && out_valid && out_ready) begin
      got.kind = kind; got.lo = out_low; got.hi = out_high;
      got.bytes = out_bytes; got.status = status;
      sb.check(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt == 5000) begin
      $display("[chacha20_poly1305_aead_core] ERROR");
      $finish;
    end
  end

  initial begin
    int msgs;
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; cmd = 0; data_low = 0; data_high = 0; valid_bytes = 0;
    repeat (8) @(negedge clk);
    rst = 0;

    load_setting(1, 1'b0);
    send(ccp_pkg::CMD_FIN, '1, '1, 5'd0);                  // empty message
    send(ccp_pkg::CMD_NONE, '1, '1, ccp_pkg::CHUNK_BYTES); // ignored command
    send(ccp_pkg::CMD_AAD, '1, '1, ccp_pkg::CHUNK_BYTES);
    send(ccp_pkg::CMD_AAD, '1, '1, 5'd0);
    send(ccp_pkg::CMD_AAD, '1, '1, 5'd5);
    send(ccp_pkg::CMD_TEXT, '1, '1, ccp_pkg::CHUNK_BYTES);
    send(ccp_pkg::CMD_TEXT, '1, '1, 5'd0);
    send(ccp_pkg::CMD_TEXT, '1, '1, 5'd9);
    send(ccp_pkg::CMD_TEXT, 64'd0, 64'd0, 5'd31);          // oversize length
    send(ccp_pkg::CMD_TEXT, '1, '1, ccp_pkg::WORD_BYTES);
    send(ccp_pkg::CMD_TEXT, rnd64(), rnd64(), 5'd1);
    send(ccp_pkg::CMD_FIN, '1, '1, 5'd31);
    send(ccp_pkg::CMD_TEXT, rnd64(), rnd64(), ccp_pkg::CHUNK_BYTES);
    send(ccp_pkg::CMD_AAD, rnd64(), rnd64(), ccp_pkg::CHUNK_BYTES);  // out of order
    send(ccp_pkg::CMD_FIN, rnd64(), rnd64(), ccp_pkg::CHUNK_BYTES);
    drain();
    load_setting(0, 1'b1);
    send(ccp_pkg::CMD_AAD, rnd64(), rnd64(), ccp_pkg::CHUNK_BYTES);
    send(ccp_pkg::CMD_TEXT, rnd64(), rnd64(), ccp_pkg::CHUNK_BYTES);
    send(ccp_pkg::CMD_TEXT, rnd64(), rnd64(), 5'd3);
    finish_msg(1'b0);
    send(ccp_pkg::CMD_TEXT, rnd64(), rnd64(), ccp_pkg::CHUNK_BYTES);
    send(ccp_pkg::CMD_FIN, rnd64(), rnd64(), ccp_pkg::CHUNK_BYTES);

    msgs = 0;
    while (n_sent < 1400) begin
      if (msgs % 12 == 0) begin
        drain();
        load_setting((msgs / 12) % 5 == 1 ? 1 : 2, 1'($urandom));
      end
      if (msgs == 20) hold_req = 1;
      quiet = (n_sent > 1250);
      message($urandom_range(0, 3), $urandom_range(0, 9), $urandom_range(0, 9) == 0);
      msgs++;
    end

    in_valid = 0;
    while (sb.expq.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0) $display("[chacha20_poly1305_aead_core] OK");
    else $display("[chacha20_poly1305_aead_core] ERROR");
    $finish;
  end

endmodule

>>> files.f
sv/ccp_pkg.sv
sv/ccp_front.sv
sv/ccp_chacha.sv
sv/ccp_poly.sv
sv/ccp_back.sv
sv/chacha20_poly1305_aead_core.sv
sim/testbench.sv
